/* rtl/core/oidset_pkg.sv */
// Shared types and constants for the ordered identifier set table.
package oidset_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned OCC_W     = 7;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Broadcast controls from the sequencer to every cell of the chain.
  typedef struct packed {
    logic capture;    // latch the compare result for a new transaction
    logic remove_en;  // close the gap at and above the matched slot
    logic add_en;     // write the identifier into the first free slot
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

endpackage

/* rtl/core/oidset_cell.sv */
// One slot of the identifier chain: holds an identifier and compares it.
module oidset_cell import oidset_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned CW  = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  cell_ctl_t       ctl,
  input  logic [ID_W-1:0] ident,
  input  logic [IW-1:0]   pos,
  input  logic [CW-1:0]   count,
  input  logic [ID_W-1:0] up_id,
  output logic [ID_W-1:0] id,
  output logic            match
);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);

  logic [ID_W-1:0] id_next;

  // On a removal every slot from the match upwards takes its upper neighbour.
  always_comb begin
    id_next = id;
    priority if (ctl.remove_en && (MY_IDX >= pos)) begin
      id_next = up_id;
    end else if (ctl.add_en && (MY_IDX_C == count)) begin
      id_next = ident;
    end else begin
      id_next = id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id <= '0;
    end else begin
      id <= id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (id == ident) && (ident != '0);
    end
  end

endmodule

/* rtl/core/oidset_encoder.sv */
// Turns the one-hot match vector of the chain into a slot number and a hit flag.
module oidset_encoder import oidset_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned IW    = 6
) (
  input  logic [SLOTS-1:0] match_vec,
  output logic [IW-1:0]    pos,
  output logic             hit
);

  // Identifiers are unique, so at most one bit is set and an OR suffices.
  always_comb begin
    pos = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_vec[i]) begin
        pos = pos | IW'(i);
      end
    end
    hit = |match_vec;
  end

endmodule

/* rtl/core/ordered_id_set_table_core.sv */
// Top level of the ordered identifier set table: sequencer, cell chain and result register.
//
// The table keeps up to SLOTS distinct nonzero 16-bit identifiers in insertion order,
// one per cell of a chain of identical cells, together with an occupancy count. Each
// input transaction carries a command (find, add or remove) and an identifier and
// produces exactly one result transaction giving ok, the slot concerned and the
// occupancy after the operation. In the cycle a transaction is accepted every cell
// compares its identifier with the incoming one and registers the outcome; then, in
// the evaluation state and once the output register can take the result, the match
// vector is encoded into a slot number, the chain is updated (a removal makes every
// cell at or above the match take its upper neighbour's identifier, an add writes the
// first free cell) and the result is loaded into the output register. The input is
// stalled throughout the evaluation state, so a new transaction is accepted only once
// the previous one has been evaluated. A result that is held by a stalled output does
// not block the next input transaction from being accepted; only its evaluation waits
// until the output register is free. Reset clears every cell and the count. Position
// is the low six bits of the slot and occupancy the low seven bits of the count.
module ordered_id_set_table_core import oidset_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  logic [ID_W-1:0]  ident,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output logic [POS_W-1:0] position,
  output logic [OCC_W-1:0] occupancy
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  state_t           state, state_next;
  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  ident_q;
  logic [CW-1:0]    count, count_next;

  logic [SLOTS-1:0]    match_vec;
  logic [ID_W-1:0]     ids [SLOTS];
  logic [IW-1:0]       hit_pos;
  logic                hit;
  cell_ctl_t           ctl;
  logic                accept;
  logic                fire;
  logic                res_ok;
  logic [IW-1:0]       res_pos;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The evaluation step may only run when the output register can take its result.
  assign fire     = (state == S_EVAL) && (!out_valid || !out_stall);

  // The cells compare against the live input identifier in the accept cycle and
  // against the held one while the chain is updated.
  logic [ID_W-1:0] cell_ident;
  assign cell_ident = accept ? ident : ident_q;

  oidset_encoder #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_encoder (
    .match_vec (match_vec),
    .pos       (hit_pos),
    .hit       (hit)
  );

  // Decide the outcome of the transaction held for evaluation.
  always_comb begin
    res_ok         = 1'b0;
    count_next     = count;
    ctl.capture    = accept;
    ctl.remove_en  = 1'b0;
    ctl.add_en     = 1'b0;
    unique case (cmd_q)
      CMD_FIND: begin
        res_ok = hit;
      end
      CMD_ADD: begin
        res_ok = (ident_q != '0) && !hit && (count != FULL);
        if (fire && res_ok) begin
          ctl.add_en = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        res_ok = hit;
        if (fire && res_ok) begin
          ctl.remove_en = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    // An add reports the slot it filled, which is the count before the add.
    if (cmd_q == CMD_ADD) begin
      res_pos = res_ok ? IW'(count) : '0;
    end else begin
      res_pos = res_ok ? hit_pos : '0;
    end
  end

  // The chain itself; the topmost cell takes zero from beyond the end.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic [ID_W-1:0] up_id;
    if (g == SLOTS - 1) begin : g_top
      assign up_id = '0;
    end else begin : g_mid
      assign up_id = ids[g+1];
    end
    oidset_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .ident (cell_ident),
      .pos   (hit_pos),
      .count (count),
      .up_id (up_id),
      .id    (ids[g]),
      .match (match_vec[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      ident_q <= ident;
    end
    if (fire) begin
      ok        <= res_ok;
      position  <= POS_W'(res_pos);
      occupancy <= OCC_W'(count_next);
    end
  end

  // The count never runs past the number of cells.
  assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("occupancy count exceeds the number of slots");

  // Stored identifiers are distinct, so a compare never hits in two cells.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> $onehot0(match_vec))
    else $error("more than one cell matched the identifier");

  // The top cell is empty whenever the table is not full.
  assert property (@(posedge clk) disable iff (rst)
    (count != FULL) |-> (ids[SLOTS-1] == '0))
    else $error("top cell holds an identifier while the table is not full");

  // An evaluation always leaves a result in the output register and frees the input.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> (out_valid && (state == S_IDLE)))
    else $error("evaluation did not deliver a result");

  // An accepted transaction always moves the sequencer into the evaluation state.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EVAL))
    else $error("accepted transaction was not taken into evaluation");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the ordered identifier set table core.
`timescale 1ns / 100ps

module testbench import oidset_pkg::*; ();

  // The fourth command encoding is unused: the table must leave its contents alone and
  // answer with a refusal and the current occupancy.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int TABLE_SLOTS  = SLOTS_DEF;
  localparam int RANDOM_OPS   = 1030;
  localparam int POOL_SIZE    = 96;   // larger than the table, so adds can fill it
  localparam int PHASE_LEN    = 200;  // random operations per grow or shrink phase
  localparam int HOLD_AFTER   = 400;  // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 8;    // time for the last evaluation plus a margin
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 20;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  ident;
    bit               drain;  // hold this transaction back until all results are in
  } table_op_t;

  typedef struct {
    logic             ok;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } outcome_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] cmd       = CMD_FIND;
  logic [ID_W-1:0]  ident     = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             ok;
  logic [POS_W-1:0] position;
  logic [OCC_W-1:0] occupancy;

  table_op_t op_queue[$];
  outcome_t  outcome_queue[$];

  // Shadow copy of the table contents, advanced once per accepted input transaction.
  logic [ID_W-1:0] shadow_ids[TABLE_SLOTS];
  int              shadow_count;

  int errors       = 0;
  int in_flight    = 0;
  int results_seen = 0;
  int cycle_count  = 0;

  ordered_id_set_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .ident     (ident),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .position  (position),
    .occupancy (occupancy)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Slot of a stored identifier, or -1. Zero never matches, as it is never stored.
  function automatic int slot_of(input logic [ID_W-1:0] id);
    if (id == '0) return -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic outcome_t table_apply(input logic [CMD_W-1:0] c,
                                           input logic [ID_W-1:0] id);
    outcome_t o;
    int       slot;
    slot       = slot_of(id);
    o.ok       = 1'b0;
    o.position = '0;
    case (c)
      CMD_FIND: begin
        if (slot >= 0) begin
          o.ok       = 1'b1;
          o.position = POS_W'(slot);
        end
      end
      CMD_ADD: begin
        // Refused for zero, for a duplicate and when the table is full.
        if (id != '0 && slot < 0 && shadow_count < TABLE_SLOTS) begin
          shadow_ids[shadow_count] = id;
          o.ok       = 1'b1;
          o.position = POS_W'(shadow_count);
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        // Later entries close up by one place and the vacated top slot is cleared.
        if (slot >= 0) begin
          for (int i = slot; i + 1 < shadow_count; i++) shadow_ids[i] = shadow_ids[i + 1];
          shadow_count--;
          shadow_ids[shadow_count] = '0;
          o.ok       = 1'b1;
          o.position = POS_W'(slot);
        end
      end
      default: begin
      end
    endcase
    o.occupancy = OCC_W'(shadow_count);
    return o;
  endfunction

  function automatic table_op_t make_op(input logic [CMD_W-1:0] c,
                                        input logic [ID_W-1:0] id, input bit drain);
    table_op_t op;
    op.cmd   = c;
    op.ident = id;
    op.drain = drain;
    return op;
  endfunction

  // Stimulus and end of run. The whole sequence of transactions is queued at time zero;
  // the driver below then feeds it to the block at its own pace.
  initial begin
    logic [ID_W-1:0]  pool[POOL_SIZE];
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0]  id;
    bit               growing;
    int               r;

    for (int i = 0; i < TABLE_SLOTS; i++) shadow_ids[i] = '0;
    shadow_count = 0;

    // Directed part: zero identifiers, misses on an empty table, the extreme
    // identifiers, a duplicate add, the unused command, and removals from the
    // front, the middle and the back of the table.
    op_queue.push_back(make_op(CMD_FIND,   16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'h1234, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'h1234, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'hFFFF, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'h0001, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'h8000, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'hFFFF, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'hFFFF, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'h8000, 1'b0));
    op_queue.push_back(make_op(CMD_UNUSED, 16'hFFFF, 1'b0));
    op_queue.push_back(make_op(CMD_UNUSED, 16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'h0001, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'h8000, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'h0001, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'h5555, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'hAAAA, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'hFFFF, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'hAAAA, 1'b0));
    op_queue.push_back(make_op(CMD_REMOVE, 16'hAAAA, 1'b0));
    op_queue.push_back(make_op(CMD_ADD,    16'h0000, 1'b0));
    op_queue.push_back(make_op(CMD_FIND,   16'h5555, 1'b0));

    // Random part. Identifiers come mostly from a pool a little larger than the table,
    // so that finds and removes hit, duplicates turn up and grow phases fill the table
    // to the brim. Grow and shrink phases alternate so that the table is driven from
    // empty to full and back. Zero identifiers, arbitrary identifiers and the unused
    // command are mixed in as noise.
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = ID_W'($urandom_range(65535, 1));
    for (int n = 0; n < RANDOM_OPS; n++) begin
      growing = ((n / PHASE_LEN) % 2) == 0;
      r = $urandom_range(99);
      if (r < 4) c = CMD_UNUSED;
      else if (growing) c = (r < 70) ? CMD_ADD : (r < 85) ? CMD_FIND : CMD_REMOVE;
      else c = (r < 20) ? CMD_ADD : (r < 40) ? CMD_FIND : CMD_REMOVE;
      r = $urandom_range(99);
      if (r < 3) id = '0;
      else if (r < 12) id = ID_W'($urandom_range(65535));
      else id = pool[$urandom_range(POOL_SIZE - 1)];
      // The sender waits for the table to go quiet at the start of the random part
      // and once more in the middle of it.
      op_queue.push_back(make_op(c, id, n == 0 || n == RANDOM_OPS / 2));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || in_flight != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (outcome_queue.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", outcome_queue.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: offers transactions in bursts of random length separated by random gaps.
  // A stalled transaction is held unchanged; a new one is chosen only once the
  // previous one has been taken or none was on offer.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    table_op_t op;
    bit        offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_queue.size() != 0 &&
                   !(op_queue[0].drain && (in_flight != 0 || in_valid))) begin
        // A transaction taken at this edge is not yet counted in in_flight, hence
        // the extra look at in_valid before a draining transaction may go.
        op    = op_queue.pop_front();
        cmd   <= op.cmd;
        ident <= op.ident;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: stalls in stretches of changing character (never, coin toss, sparse,
  // periodic), and once holds the output off for a long stretch so that the block
  // fills up and has to stall its input while the driver keeps offering.
  int stall_style  = 0;
  int pattern_left = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_style  <= $urandom_range(3);
        pattern_left <= $urandom_range(80, 10);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(1) == 1;
        2: out_stall <= $urandom_range(3) == 0;
        default: out_stall <= (cycle_count % 3) == 0;
      endcase
    end
  end

  // Monitor: checks each result transaction against the oldest expectation, then
  // predicts the result of any input transaction taken at the same edge. Doing both
  // in one process keeps the expectation queue free of ordering races.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (outcome_queue.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = outcome_queue.pop_front();
          if (ok !== want.ok) begin
            report_mismatch($sformatf("ok expected %0d got %0d", want.ok, ok));
          end
          if (position !== want.position) begin
            report_mismatch($sformatf("position expected %0d got %0d",
                                      want.position, position));
          end
          if (occupancy !== want.occupancy) begin
            report_mismatch($sformatf("occupancy expected %0d got %0d",
                                      want.occupancy, occupancy));
          end
        end
      end
      if (in_valid && !in_stall) begin
        outcome_queue.push_back(table_apply(cmd, ident));
      end
      in_flight <= outcome_queue.size();
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/oidset_pkg.sv
rtl/core/oidset_cell.sv
rtl/core/oidset_encoder.sv
rtl/core/ordered_id_set_table_core.sv
test/testbench.sv
